// ===== rtl/core/fbla_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbla_pkg: shared types and constants of the block pool allocator
// Transaction layouts, operation and status codes, register indexes and the
// fixed widths of the index space, the counters and the byte offset.
// ----------------------------------------------------------------------------
package fbla_pkg;

    // Index space and field widths.
    localparam int INDEX_SPACE = 1024;
    localparam int INDEX_W     = 10;
    localparam int COUNT_W     = 11;
    localparam int OFFSET_W    = 22;
    localparam logic [OFFSET_W-1:0] OFFSET_MAX = 22'h3FFFFF;

    // Smallest block and smallest alignment; a power of two.
    localparam int LINK_BYTES = 8;

    // Effective block size width: up to 2^15 for the largest alignment code.
    localparam int SIZE_W = 17;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;
    localparam int ALIGN_W    = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALIGN      = 1'd1;

    // Operation codes; the last one is unassigned and does nothing.
    localparam logic [1:0] FUNC_ALLOC  = 2'd0;
    localparam logic [1:0] FUNC_FREE   = 2'd1;
    localparam logic [1:0] FUNC_RESET  = 2'd2;
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    // Status codes.
    localparam logic [1:0] STATUS_OK            = 2'd0;
    localparam logic [1:0] STATUS_OUT_OF_BLOCKS = 2'd1;
    localparam logic [1:0] STATUS_FOREIGN       = 2'd2;
    localparam logic [1:0] STATUS_NONE_OUT      = 2'd3;

    // Request transaction.
    typedef struct packed {
        logic [1:0]         func;
        logic [INDEX_W-1:0] block_index;
        logic               block_null;
    } req_item_t;

    // Response transaction.
    typedef struct packed {
        logic [1:0]          status;
        logic [INDEX_W-1:0]  granted_index;
        logic [OFFSET_W-1:0] byte_offset;
        logic [COUNT_W-1:0]  used_count;
        logic [COUNT_W-1:0]  peak_count;
        logic [COUNT_W-1:0]  total_blocks;
    } rsp_item_t;

    // Result of the free list controller, without the byte offset.
    typedef struct packed {
        logic [1:0]         status;
        logic [INDEX_W-1:0] granted_index;
        logic [COUNT_W-1:0] used_count;
        logic [COUNT_W-1:0] peak_count;
        logic [COUNT_W-1:0] total_blocks;
    } fl_result_t;

    // Free list sequencer states.
    typedef enum logic [1:0] {
        FL_LINK,
        FL_IDLE,
        FL_ISSUE,
        FL_EXEC
    } fl_state_t;

endpackage

// ===== rtl/core/fixed_block_free_list_allocator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator_top: fixed-size block pool allocator
// Allocates, frees and resets blocks of a pool kept as a LIFO free list in a
// link memory, and reports the byte offset and the usage counters.
//
//   Channel  Handshake               Payload
//   req      req_valid / req_stall   req_item_t: func, block_index, block_null
//   rsp      rsp_valid / rsp_stall   rsp_item_t: status, granted_index, ...
//   cfg      cfg_we                  cfg_index, cfg_data (no read-back)
//
// An allocate, a free or an unused code first reads the link of the list head
// from the memory, then updates the list and the counters. An allocate that
// activates a chunk first sweeps the links of the chunk, one memory write per
// cycle, and then reads the new head. A block reset answers first and then
// sweeps total_blocks entries before the next request. After reset the memory
// sweep of chunk zero runs with req_stall high. A stalled response holds the
// update step.
// ----------------------------------------------------------------------------
module fixed_block_free_list_allocator_top #(
    parameter int BLOCKS_PER_CHUNK = 64,
    parameter int MAX_CHUNKS       = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  fbla_pkg::req_item_t             req_data,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output fbla_pkg::rsp_item_t             rsp_data,
    input  logic                            cfg_we,
    input  logic [fbla_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fbla_pkg::CFG_DATA_W-1:0] cfg_data
);

    logic [fbla_pkg::CFG_DATA_W-1:0] block_size_request_reg;
    logic [fbla_pkg::ALIGN_W-1:0]    align_log2_reg;

    logic                            busy;
    logic                            start;
    logic                            done;
    logic                            out_free;
    fbla_pkg::fl_result_t            result;
    logic [fbla_pkg::OFFSET_W-1:0]   byte_offset;

    logic                            rsp_valid_reg, rsp_valid_next;
    fbla_pkg::rsp_item_t             rsp_data_reg, rsp_data_next;

    assign req_stall = busy;
    assign start     = req_valid && !busy;
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_size_request_reg <= fbla_pkg::CFG_DATA_W'(8);
            align_log2_reg         <= fbla_pkg::ALIGN_W'(3);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                fbla_pkg::CFG_BLOCK_SIZE:
                begin
                    block_size_request_reg <= cfg_data;
                end
                fbla_pkg::CFG_ALIGN:
                begin
                    align_log2_reg <= cfg_data[fbla_pkg::ALIGN_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // Free list controller with its link memory.
    fbla_free_list #(
        .BLOCKS_PER_CHUNK (BLOCKS_PER_CHUNK),
        .MAX_CHUNKS       (MAX_CHUNKS)
    ) u_free_list (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .item     (req_data),
        .out_free (out_free),
        .busy     (busy),
        .done     (done),
        .result   (result)
    );

    // Byte offset of the granted block.
    fbla_offset u_offset (
        .block_size_request (block_size_request_reg),
        .align_log2         (align_log2_reg),
        .granted_index      (result.granted_index),
        .byte_offset        (byte_offset)
    );

    // Response register: loaded when a result is done, cleared when taken.
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_data_next  = rsp_data_reg;
        if (done)
        begin
            rsp_valid_next              = 1'b1;
            rsp_data_next.status        = result.status;
            rsp_data_next.granted_index = result.granted_index;
            rsp_data_next.byte_offset   = byte_offset;
            rsp_data_next.used_count    = result.used_count;
            rsp_data_next.peak_count    = result.peak_count;
            rsp_data_next.total_blocks  = result.total_blocks;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_data_reg <= rsp_data_next;
    end

endmodule

// ===== rtl/core/fbla_offset.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbla_offset: byte offset of a granted block
// Derives the effective block size from the configured request and alignment
// and multiplies it by the granted index, saturating to the offset width.
// ----------------------------------------------------------------------------
module fbla_offset (
    input  logic [fbla_pkg::CFG_DATA_W-1:0] block_size_request,
    input  logic [fbla_pkg::ALIGN_W-1:0]    align_log2,
    input  logic [fbla_pkg::INDEX_W-1:0]    granted_index,
    output logic [fbla_pkg::OFFSET_W-1:0]   byte_offset
);

    localparam int PROD_W = fbla_pkg::INDEX_W + fbla_pkg::SIZE_W;

    logic [fbla_pkg::SIZE_W-1:0] align_bytes;
    logic [fbla_pkg::SIZE_W-1:0] size_min;
    logic [fbla_pkg::SIZE_W-1:0] size_up;
    logic [fbla_pkg::SIZE_W-1:0] eff_size;
    logic [PROD_W-1:0]           product;

    // Effective alignment and size, both at least one link wide.
    always_comb
    begin
        align_bytes = fbla_pkg::SIZE_W'(1) << align_log2;
        if (align_bytes < fbla_pkg::SIZE_W'(fbla_pkg::LINK_BYTES))
        begin
            align_bytes = fbla_pkg::SIZE_W'(fbla_pkg::LINK_BYTES);
        end
        size_min = fbla_pkg::SIZE_W'(block_size_request);
        if (size_min < fbla_pkg::SIZE_W'(fbla_pkg::LINK_BYTES))
        begin
            size_min = fbla_pkg::SIZE_W'(fbla_pkg::LINK_BYTES);
        end
        // The alignment is a power of two, so rounding up is an add and a mask.
        size_up  = size_min + align_bytes - fbla_pkg::SIZE_W'(1);
        eff_size = size_up & ~(align_bytes - fbla_pkg::SIZE_W'(1));
    end

    // Offset multiply with saturation.
    always_comb
    begin
        product = PROD_W'(granted_index) * PROD_W'(eff_size);
        if (product > PROD_W'(fbla_pkg::OFFSET_MAX))
        begin
            byte_offset = fbla_pkg::OFFSET_MAX;
        end
        else
        begin
            byte_offset = product[fbla_pkg::OFFSET_W-1:0];
        end
    end

endmodule

// ===== rtl/core/fbla_free_list.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbla_free_list: link memory and free list sequencer
// Holds the next-link memory, the list head and the counters. Pops and pushes
// the LIFO list and sweeps index ranges into the memory when a chunk is
// activated, on a block reset and after power-on reset.
// ----------------------------------------------------------------------------
module fbla_free_list #(
    parameter int BLOCKS_PER_CHUNK = 64,
    parameter int MAX_CHUNKS       = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  fbla_pkg::req_item_t  item,
    input  logic                 out_free,
    output logic                 busy,
    output logic                 done,
    output fbla_pkg::fl_result_t result
);

    localparam int CHUNKS_BY_SPACE = fbla_pkg::INDEX_SPACE / BLOCKS_PER_CHUNK;
    localparam int CHUNK_LIMIT     = (MAX_CHUNKS < CHUNKS_BY_SPACE) ? MAX_CHUNKS
                                                                    : CHUNKS_BY_SPACE;
    localparam int TOTAL_MAX       = CHUNK_LIMIT * BLOCKS_PER_CHUNK;

    localparam logic [fbla_pkg::COUNT_W-1:0] CHUNK_BLOCKS =
        fbla_pkg::COUNT_W'(BLOCKS_PER_CHUNK);
    localparam logic [fbla_pkg::COUNT_W-1:0] TOTAL_LIMIT  = fbla_pkg::COUNT_W'(TOTAL_MAX);

    // Link memory, one entry per block index.
    logic [fbla_pkg::INDEX_W-1:0] link_mem [fbla_pkg::INDEX_SPACE];
    logic [fbla_pkg::INDEX_W-1:0] rd_data_reg;
    logic                         mem_we;
    logic [fbla_pkg::INDEX_W-1:0] mem_waddr;
    logic [fbla_pkg::INDEX_W-1:0] mem_wdata;

    fbla_pkg::fl_state_t          state_reg, state_next;
    logic [fbla_pkg::INDEX_W-1:0] head_reg, head_next;
    logic                         nonempty_reg, nonempty_next;
    logic [fbla_pkg::COUNT_W-1:0] used_reg, used_next;
    logic [fbla_pkg::COUNT_W-1:0] peak_reg, peak_next;
    logic [fbla_pkg::COUNT_W-1:0] total_reg, total_next;
    logic [fbla_pkg::INDEX_W-1:0] sweep_addr_reg, sweep_addr_next;
    logic [fbla_pkg::INDEX_W-1:0] sweep_last_reg, sweep_last_next;
    logic                         sweep_alloc_reg, sweep_alloc_next;
    fbla_pkg::req_item_t          item_reg, item_next;

    logic                         at_last;
    logic                         can_grow;
    logic                         need_grow;
    logic [fbla_pkg::COUNT_W-1:0] used_inc;
    logic [fbla_pkg::COUNT_W-1:0] range_end;

    assign at_last   = (sweep_addr_reg == sweep_last_reg);
    assign can_grow  = (total_reg < TOTAL_LIMIT);
    assign need_grow = (item_reg.func == fbla_pkg::FUNC_ALLOC) && !nonempty_reg && can_grow;
    assign used_inc  = used_reg + fbla_pkg::COUNT_W'(1);
    assign range_end = total_reg + CHUNK_BLOCKS - fbla_pkg::COUNT_W'(1);
    assign busy      = (state_reg != fbla_pkg::FL_IDLE);

    // Memory: one write port, one read port at the list head, registered read.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            link_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= link_mem[head_reg];
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fbla_pkg::FL_LINK:
            begin
                if (at_last)
                begin
                    state_next = sweep_alloc_reg ? fbla_pkg::FL_ISSUE : fbla_pkg::FL_IDLE;
                end
            end
            fbla_pkg::FL_IDLE:
            begin
                if (start)
                begin
                    state_next = fbla_pkg::FL_EXEC;
                end
            end
            fbla_pkg::FL_ISSUE:
            begin
                state_next = fbla_pkg::FL_EXEC;
            end
            fbla_pkg::FL_EXEC:
            begin
                if (need_grow)
                begin
                    state_next = fbla_pkg::FL_LINK;
                end
                else if (out_free)
                begin
                    state_next = (item_reg.func == fbla_pkg::FUNC_RESET) ? fbla_pkg::FL_LINK
                                                                          : fbla_pkg::FL_IDLE;
                end
            end
            default:
            begin
                state_next = fbla_pkg::FL_IDLE;
            end
        endcase
    end

    // Datapath and memory controls.
    always_comb
    begin
        head_next        = head_reg;
        nonempty_next    = nonempty_reg;
        used_next        = used_reg;
        peak_next        = peak_reg;
        total_next       = total_reg;
        sweep_addr_next  = sweep_addr_reg;
        sweep_last_next  = sweep_last_reg;
        sweep_alloc_next = sweep_alloc_reg;
        item_next        = item_reg;
        mem_we           = 1'b0;
        mem_waddr        = sweep_addr_reg;
        mem_wdata        = '0;
        done             = 1'b0;
        result           = '0;
        result.status    = fbla_pkg::STATUS_OK;
        case (state_reg)
            fbla_pkg::FL_LINK:
            begin
                // Link the range in index order; the last entry gets zero.
                mem_we          = 1'b1;
                mem_wdata       = at_last ? '0 : sweep_addr_reg + fbla_pkg::INDEX_W'(1);
                sweep_addr_next = sweep_addr_reg + fbla_pkg::INDEX_W'(1);
            end
            fbla_pkg::FL_IDLE:
            begin
                if (start)
                begin
                    item_next = item;
                end
            end
            fbla_pkg::FL_ISSUE:
            begin
                // The link of the new head is being read.
            end
            fbla_pkg::FL_EXEC:
            begin
                case (item_reg.func)
                    fbla_pkg::FUNC_ALLOC:
                    begin
                        if (need_grow)
                        begin
                            // Activate the next chunk and sweep its links.
                            head_next        = total_reg[fbla_pkg::INDEX_W-1:0];
                            sweep_addr_next  = total_reg[fbla_pkg::INDEX_W-1:0];
                            sweep_last_next  = range_end[fbla_pkg::INDEX_W-1:0];
                            total_next       = total_reg + CHUNK_BLOCKS;
                            nonempty_next    = 1'b1;
                            sweep_alloc_next = 1'b1;
                        end
                        else if (out_free)
                        begin
                            done = 1'b1;
                            if (!nonempty_reg)
                            begin
                                result.status = fbla_pkg::STATUS_OUT_OF_BLOCKS;
                            end
                            else
                            begin
                                // Pop the head; its link is in the read register.
                                result.granted_index = head_reg;
                                head_next            = rd_data_reg;
                                used_next            = used_inc;
                                if (used_inc > peak_reg)
                                begin
                                    peak_next = used_inc;
                                end
                                nonempty_next = (used_inc < total_reg);
                            end
                        end
                    end
                    fbla_pkg::FUNC_FREE:
                    begin
                        if (out_free)
                        begin
                            done = 1'b1;
                            if (item_reg.block_null)
                            begin
                                result.status = fbla_pkg::STATUS_OK;
                            end
                            else if (used_reg == '0)
                            begin
                                result.status = fbla_pkg::STATUS_NONE_OUT;
                            end
                            else if (fbla_pkg::COUNT_W'(item_reg.block_index) >= total_reg)
                            begin
                                result.status = fbla_pkg::STATUS_FOREIGN;
                            end
                            else
                            begin
                                // Push the block in front of the current head.
                                mem_we        = 1'b1;
                                mem_waddr     = item_reg.block_index;
                                mem_wdata     = head_reg;
                                head_next     = item_reg.block_index;
                                nonempty_next = 1'b1;
                                used_next     = used_reg - fbla_pkg::COUNT_W'(1);
                            end
                        end
                    end
                    fbla_pkg::FUNC_RESET:
                    begin
                        if (out_free)
                        begin
                            // Answer now, then relink every active block.
                            done             = 1'b1;
                            used_next        = '0;
                            head_next        = '0;
                            nonempty_next    = 1'b1;
                            sweep_addr_next  = '0;
                            sweep_last_next  = fbla_pkg::INDEX_W'(total_reg -
                                                                  fbla_pkg::COUNT_W'(1));
                            sweep_alloc_next = 1'b0;
                        end
                    end
                    default:
                    begin
                        done = out_free;
                    end
                endcase
            end
            default:
            begin
            end
        endcase
        result.used_count   = used_next;
        result.peak_count   = peak_next;
        result.total_blocks = total_next;
    end

    // Control registers; after reset chunk zero is swept into the memory.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= fbla_pkg::FL_LINK;
            head_reg        <= '0;
            nonempty_reg    <= 1'b1;
            used_reg        <= '0;
            peak_reg        <= '0;
            total_reg       <= CHUNK_BLOCKS;
            sweep_addr_reg  <= '0;
            sweep_last_reg  <= fbla_pkg::INDEX_W'(BLOCKS_PER_CHUNK - 1);
            sweep_alloc_reg <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            head_reg        <= head_next;
            nonempty_reg    <= nonempty_next;
            used_reg        <= used_next;
            peak_reg        <= peak_next;
            total_reg       <= total_next;
            sweep_addr_reg  <= sweep_addr_next;
            sweep_last_reg  <= sweep_last_next;
            sweep_alloc_reg <= sweep_alloc_next;
        end
    end

    // Captured request payload.
    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the fixed-size block pool allocator
// Keeps its own model of the free list, chunk activation and usage counters.
// Each accepted request transaction is predicted and each response is
// compared field by field. A directed opening covers the special cases.
// Random segments then grow, drain and churn the pool, including one long
// fill up to out of blocks. Block size and alignment are changed between
// phases, and both handshakes are stalled at random.
// ----------------------------------------------------------------------------
module testbench;

    import fbla_pkg::*;

    localparam int POOL_CHUNK      = 64;
    localparam int POOL_MAX_CHUNKS = 16;
    localparam int CHUNK_LIMIT     = (POOL_MAX_CHUNKS < INDEX_SPACE / POOL_CHUNK) ?
                                     POOL_MAX_CHUNKS : INDEX_SPACE / POOL_CHUNK;
    localparam int RANDOM_ITEMS    = 1800;
    localparam int PHASE_ITEMS     = 300;
    localparam int FILL_START      = 150;
    localparam int FILL_ITEMS      = 1100;
    // A block reset sweeps every active link after it answers.
    localparam int SETTLE_CYCLES   = INDEX_SPACE + POOL_CHUNK + 16;
    localparam int PRINT_LIMIT     = 100;

    typedef enum int {
        SEG_FILL,
        SEG_GROW,
        SEG_SHRINK,
        SEG_CHURN
    } seg_kind_t;

    // Free list model and the queue of responses still owed by the block.
    class pool_scoreboard;
        logic [INDEX_W-1:0] link_mem [INDEX_SPACE];
        int unsigned        list_head;
        bit                 list_nonempty;
        int unsigned        active_chunks;
        int unsigned        used_blocks;
        int unsigned        peak_blocks;
        int unsigned        size_request;
        int unsigned        align_code;
        rsp_item_t          awaited_results[$];
        int                 error_count;

        function new();
            foreach (link_mem[i])
                link_mem[i] = '0;
            size_request  = 8;
            align_code    = 3;
            active_chunks = 1;
            used_blocks   = 0;
            peak_blocks   = 0;
            error_count   = 0;
            link_run(0, POOL_CHUNK - 1);
        endfunction

        // Link first..last in ascending order and make first the head.
        function void link_run(int unsigned first, int unsigned last);
            for (int unsigned i = first; i < last; i++)
                link_mem[i % INDEX_SPACE] = INDEX_W'((i + 1) % INDEX_SPACE);
            link_mem[last % INDEX_SPACE] = '0;
            list_head     = first % INDEX_SPACE;
            list_nonempty = 1'b1;
        endfunction

        function int unsigned total_blocks_now();
            return active_chunks * POOL_CHUNK;
        endfunction

        function int unsigned pending();
            return awaited_results.size();
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] index,
                                   logic [CFG_DATA_W-1:0] data);
            if (index == CFG_BLOCK_SIZE)
                size_request = data;
            else
                align_code = data[ALIGN_W-1:0];
        endfunction

        // Request size raised to the link size, rounded up to the alignment.
        function int unsigned eff_block_size();
            int unsigned a;
            int unsigned s;
            a = 1 << align_code;
            s = size_request;
            if (a < LINK_BYTES)
                a = LINK_BYTES;
            if (s < LINK_BYTES)
                s = LINK_BYTES;
            return ((s + a - 1) / a) * a;
        endfunction

        // Apply one request to the model and queue the response it owes.
        function rsp_item_t predict_item(req_item_t item);
            rsp_item_t          r;
            bit                 ok;
            int unsigned        first;
            logic [INDEX_W-1:0] grant;
            longint unsigned    offset;
            r = '0;
            case (item.func)
                FUNC_ALLOC:
                begin
                    ok = 1'b1;
                    if (!list_nonempty) begin
                        if (active_chunks < CHUNK_LIMIT) begin
                            first = total_blocks_now();
                            active_chunks++;
                            link_run(first, first + POOL_CHUNK - 1);
                        end
                        else begin
                            ok       = 1'b0;
                            r.status = STATUS_OUT_OF_BLOCKS;
                        end
                    end
                    if (ok) begin
                        grant     = INDEX_W'(list_head);
                        list_head = link_mem[grant];
                        used_blocks++;
                        if (used_blocks > peak_blocks)
                            peak_blocks = used_blocks;
                        list_nonempty = used_blocks < total_blocks_now();
                        offset = longint'(grant) * longint'(eff_block_size());
                        if (offset > longint'(OFFSET_MAX))
                            offset = longint'(OFFSET_MAX);
                        r.granted_index = grant;
                        r.byte_offset   = OFFSET_W'(offset);
                    end
                end
                FUNC_FREE:
                begin
                    if (!item.block_null) begin
                        if (used_blocks == 0)
                            r.status = STATUS_NONE_OUT;
                        else if (int'(item.block_index) >= total_blocks_now())
                            r.status = STATUS_FOREIGN;
                        else begin
                            link_mem[item.block_index] = INDEX_W'(list_head);
                            list_head     = item.block_index;
                            list_nonempty = 1'b1;
                            used_blocks--;
                        end
                    end
                end
                FUNC_RESET:
                begin
                    used_blocks = 0;
                    link_run(0, total_blocks_now() - 1);
                end
                default:
                begin
                end
            endcase
            r.used_count   = COUNT_W'(used_blocks);
            r.peak_count   = COUNT_W'(peak_blocks);
            r.total_blocks = COUNT_W'(total_blocks_now());
            awaited_results = {awaited_results, r};
            return r;
        endfunction

        task report(string what, longint got, longint want);
            if (error_count < PRINT_LIMIT)
                $display("%0t mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
            error_count++;
        endtask

        // Compare one accepted response with the oldest prediction.
        task check_response(rsp_item_t got);
            rsp_item_t want;
            if (awaited_results.size() == 0) begin
                report("response with no transaction pending", longint'(got.status), 0);
            end
            else begin
                want = awaited_results.pop_front();
                if (got.status !== want.status)
                    report("status", got.status, want.status);
                if (got.granted_index !== want.granted_index)
                    report("granted_index", got.granted_index, want.granted_index);
                if (got.byte_offset !== want.byte_offset)
                    report("byte_offset", got.byte_offset, want.byte_offset);
                if (got.used_count !== want.used_count)
                    report("used_count", got.used_count, want.used_count);
                if (got.peak_count !== want.peak_count)
                    report("peak_count", got.peak_count, want.peak_count);
                if (got.total_blocks !== want.total_blocks)
                    report("total_blocks", got.total_blocks, want.total_blocks);
            end
        endtask
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  req_valid;
    logic                  req_stall;
    req_item_t             req_data;
    logic                  rsp_valid;
    logic                  rsp_stall = 1'b0;
    rsp_item_t             rsp_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    pool_scoreboard     sb = new();
    int                 send_idle_pct = 33;
    int                 recv_idle_pct = 74;
    logic [INDEX_W-1:0] handed_out[$];

    fixed_block_free_list_allocator_top #(
        .BLOCKS_PER_CHUNK (POOL_CHUNK),
        .MAX_CHUNKS       (POOL_MAX_CHUNKS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock with a 10 ns period.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Response side: random stall, changed on the falling edge.
    always @(negedge clk)
    begin
        rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    // Every response taken at a rising edge is checked at once.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check_response(rsp_data);
    end

    // Hard limit on the run time.
    initial
    begin
        #5_000_000;
        $display("testbench: errors");
        $finish;
    end

    // Offer one request transaction, starting and ending on a falling edge.
    task send_request(input req_item_t item);
        rsp_item_t r;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= item;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        r = sb.predict_item(item);
        // Keep track of blocks that are out, so frees mostly return real ones.
        if (item.func == FUNC_ALLOC && r.status == STATUS_OK)
            handed_out = {handed_out, r.granted_index};
        else if (item.func == FUNC_RESET)
            handed_out.delete();
        @(negedge clk);
    endtask

    // Stop sending until every response is in, then let any sweep finish.
    task drain_results();
        req_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    task write_register(input logic [CFG_IDX_W-1:0] index,
                        input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.set_register(index, data);
        @(negedge clk);
    endtask

    task set_pool_config(input int unsigned size, input int unsigned align);
        write_register(CFG_BLOCK_SIZE, CFG_DATA_W'(size));
        write_register(CFG_ALIGN, CFG_DATA_W'(align));
    endtask

    function automatic req_item_t make_op(logic [1:0] func, int unsigned index, bit is_null);
        req_item_t it;
        it.func        = func;
        it.block_index = INDEX_W'(index);
        it.block_null  = is_null;
        return it;
    endfunction

    // Odd requests: null frees, foreign frees, stray frees, unused code, reset.
    function automatic req_item_t make_noise();
        int unsigned tot;
        int unsigned roll;
        tot  = sb.total_blocks_now();
        roll = $urandom_range(0, 7);
        case (roll)
            0, 1:    return make_op(FUNC_FREE, $urandom_range(0, INDEX_SPACE - 1), 1'b1);
            2, 3:    return make_op(FUNC_FREE, (tot < INDEX_SPACE) ?
                                    $urandom_range(tot, INDEX_SPACE - 1) :
                                    $urandom_range(0, INDEX_SPACE - 1), 1'b0);
            4, 5:    return make_op(FUNC_FREE, $urandom_range(0, INDEX_SPACE - 1), 1'b0);
            6:       return make_op(FUNC_UNUSED, $urandom_range(0, INDEX_SPACE - 1),
                                    $urandom_range(0, 1));
            default: return make_op(FUNC_RESET, $urandom_range(0, INDEX_SPACE - 1),
                                    $urandom_range(0, 1));
        endcase
    endfunction

    // Free a block that was handed out, or allocate if none is out.
    function automatic req_item_t make_owned_free();
        int unsigned pos;
        logic [INDEX_W-1:0] blk;
        if (handed_out.size() == 0)
            return make_op(FUNC_ALLOC, $urandom_range(0, INDEX_SPACE - 1), $urandom_range(0, 1));
        pos = $urandom_range(0, handed_out.size() - 1);
        blk = handed_out[pos];
        handed_out.delete(pos);
        return make_op(FUNC_FREE, blk, 1'b0);
    endfunction

    function automatic req_item_t make_item(seg_kind_t kind);
        int unsigned roll;
        int unsigned alloc_pct;
        int unsigned free_pct;
        roll = $urandom_range(0, 99);
        case (kind)
            SEG_FILL:
            begin
                alloc_pct = 96;
                free_pct  = 4;
            end
            SEG_GROW:
            begin
                alloc_pct = 65;
                free_pct  = 20;
            end
            SEG_SHRINK:
            begin
                alloc_pct = 20;
                free_pct  = 60;
            end
            default:
            begin
                alloc_pct = 40;
                free_pct  = 35;
            end
        endcase
        if (roll < alloc_pct)
            return make_op(FUNC_ALLOC, $urandom_range(0, INDEX_SPACE - 1), $urandom_range(0, 1));
        if (roll < alloc_pct + free_pct)
            return make_owned_free();
        return make_noise();
    endfunction

    // Main sequence.
    initial
    begin
        seg_kind_t seg;
        int        seg_left;
        bit        filled;
        req_valid = 1'b0;
        req_data  = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        rst_n     = 1'b0;
        repeat (4)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (POOL_CHUNK + 8)
            @(negedge clk);
        set_pool_config(8, 3);

        // Directed opening: error statuses, null and double free, unused code, block reset.
        send_request(make_op(FUNC_FREE, 5, 1'b0));
        send_request(make_op(FUNC_FREE, 0, 1'b1));
        send_request(make_op(FUNC_ALLOC, 0, 1'b0));
        send_request(make_op(FUNC_ALLOC, INDEX_SPACE - 1, 1'b1));
        send_request(make_op(FUNC_FREE, INDEX_SPACE - 1, 1'b0));
        send_request(make_op(FUNC_FREE, POOL_CHUNK, 1'b0));
        send_request(make_op(FUNC_FREE, 1, 1'b0));
        send_request(make_op(FUNC_FREE, 1, 1'b0));
        send_request(make_op(FUNC_ALLOC, 0, 1'b0));
        send_request(make_op(FUNC_ALLOC, 0, 1'b0));
        send_request(make_op(FUNC_UNUSED, INDEX_SPACE - 1, 1'b1));
        send_request(make_op(FUNC_UNUSED, 0, 1'b0));
        send_request(make_op(FUNC_ALLOC, 0, 1'b0));
        send_request(make_op(FUNC_FREE, POOL_CHUNK - 1, 1'b0));
        send_request(make_op(FUNC_RESET, 0, 1'b0));
        send_request(make_op(FUNC_ALLOC, 0, 1'b0));
        send_request(make_op(FUNC_FREE, 0, 1'b1));
        send_request(make_op(FUNC_FREE, 0, 1'b0));
        send_request(make_op(FUNC_ALLOC, 0, 1'b0));
        send_request(make_op(FUNC_RESET, INDEX_SPACE - 1, 1'b1));
        send_request(make_op(FUNC_ALLOC, 0, 1'b0));

        // Random segments; the configuration changes at each phase start.
        seg_left = 0;
        filled   = 1'b0;
        seg      = SEG_GROW;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % PHASE_ITEMS == 0) begin
                drain_results();
                case (n / PHASE_ITEMS)
                    0:       set_pool_config(1, 0);
                    1:       set_pool_config(4096, 12);
                    2:       set_pool_config(4095, 0);
                    3:       set_pool_config(1, 12);
                    default: set_pool_config($urandom_range(1, 4096), $urandom_range(0, 12));
                endcase
            end
            if (n == RANDOM_ITEMS / 3) begin
                send_idle_pct = 74;
                recv_idle_pct = 33;
            end
            if (n == 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (seg_left == 0) begin
                if (!filled && n >= FILL_START) begin
                    // One long run that activates every chunk and hits the limit.
                    seg      = SEG_FILL;
                    seg_left = FILL_ITEMS;
                    filled   = 1'b1;
                end
                else begin
                    seg      = seg_kind_t'($urandom_range(SEG_GROW, SEG_CHURN));
                    seg_left = $urandom_range(20, 120);
                end
            end
            send_request(make_item(seg));
            seg_left--;
        end

        // Wind down and decide.
        req_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (16)
            @(negedge clk);
        if (sb.error_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

// ===== fixed_block_free_list_allocator_top.f =====
rtl/core/fbla_pkg.sv
rtl/core/fbla_offset.sv
rtl/core/fbla_free_list.sv
rtl/core/fixed_block_free_list_allocator_top.sv
verif/testbench.sv
